FILE: rtl/dcm_pkg.sv
// ----------------------------------------------------------------------------
// dcm_pkg
// shared widths, constants, codes and control structs of the congestion
// marker
// ----------------------------------------------------------------------------
`default_nettype none

package dcm_pkg;

   // field widths
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned CE_W       = 8;
   localparam int unsigned MAXC_W     = 16;
   localparam int unsigned STAGE_W    = 8;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 16;

   // datapath widths
   localparam int unsigned MUL_W      = 16;
   localparam int unsigned PROD_W     = 2 * MUL_W;
   localparam int unsigned DIVD_W     = CNT_W + STAGE_W;
   localparam int unsigned DIVSR_W    = MAXC_W + 1;
   localparam int unsigned STEP_W     = 4;

   // counter ceiling and divide-by-ten reciprocal
   localparam logic [CNT_W-1:0] CNT_CEILING = 16'd62000;
   localparam logic [MUL_W-1:0] DECAY_RECIP = 16'd52429;
   localparam int unsigned      DECAY_SHIFT = 19;

   // level saturation value
   localparam logic [CE_W-1:0]  LEVEL_MAX   = 8'hFF;

   // command codes
   typedef enum logic [0:0] {
      CMD_PKT  = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CONGESTION = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE_COUNT    = 8'd1;

   // divider control and status
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

FILE: rtl/dcm_if.sv
// ----------------------------------------------------------------------------
// dcm_if
// valid/ready channels of the congestion marker: request, response and
// register write
// ----------------------------------------------------------------------------
`default_nettype none

interface dcm_req_if;
   logic                     valid;
   logic                     ready;
   logic [0:0]               cmd;
   logic [dcm_pkg::CNT_W-1:0] pkt_bytes;
   logic [dcm_pkg::CE_W-1:0]  pkt_ce_in;
   logic                     no_mark;

   modport source (output valid, cmd, pkt_bytes, pkt_ce_in, no_mark, input ready);
   modport sink   (input valid, cmd, pkt_bytes, pkt_ce_in, no_mark, output ready);
endinterface

interface dcm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [dcm_pkg::CE_W-1:0]  pkt_ce_out;
   logic [dcm_pkg::CE_W-1:0]  level;
   logic [dcm_pkg::CNT_W-1:0] byte_count;

   modport source (output valid, pkt_ce_out, level, byte_count, input ready);
   modport sink   (input valid, pkt_ce_out, level, byte_count, output ready);
endinterface

interface dcm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [dcm_pkg::CSR_IDX_W-1:0]  index;
   logic [dcm_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/dcm_congestion_marker_core.sv
// ----------------------------------------------------------------------------
// dre_congestion_marker_core
// link congestion estimator: saturating byte counter, quantized congestion
// level and packet marking, with decay ticks
// ----------------------------------------------------------------------------
`default_nettype none

// One word is taken at a time and req ready is low until it is finished.
// For a packet word the counter is updated on acceptance, S_MUL uses the
// shared 16 x 16 multiplier to form count * stage_count, S_DIV_GO starts the
// restoring divider, which produces one quotient bit per cycle, S_DIV_WAIT
// sees it finish and S_RESP loads the response register; that load frees the
// sequencer unless the previous response is still waiting, in which case the
// block holds. A decay tick gives no response: the same multiplier forms
// count * 52429 and the counter takes bits 31:19, which is count / 10 rounded
// down. Register writes are always accepted and take effect at once, so they
// belong between words, with nothing in flight.
module dre_congestion_marker_core (
   input  wire logic  clock,
   input  wire logic  reset,
   dcm_req_if.sink    req_ch,
   dcm_rsp_if.source  rsp_ch,
   dcm_csr_if.sink    csr_ch
);
   import dcm_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_MUL      = 6'b000010,
      S_DECAY    = 6'b000100,
      S_DIV_GO   = 6'b001000,
      S_DIV_WAIT = 6'b010000,
      S_RESP     = 6'b100000
   } state_type;

   state_type          state_ff;
   state_type          state_in;

   logic [MAXC_W-1:0]  max_cong_ff;
   logic [STAGE_W-1:0] stage_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               tick_ff;
   logic               no_mark_ff;
   logic [CE_W-1:0]    ce_in_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [CE_W-1:0]    rsp_ce_ff;
   logic [CE_W-1:0]    rsp_level_ff;
   logic [CNT_W-1:0]   rsp_count_ff;

   logic               req_take;
   logic               rsp_load;
   logic [CNT_W:0]     sum;
   logic [MUL_W-1:0]   mul_b;
   logic [PROD_W-1:0]  prod;
   logic [DIVSR_W-1:0] divisor;
   logic [CE_W-1:0]    level;
   logic [CE_W-1:0]    ce_out;
   div_ctrl_type       div_ctrl;
   div_stat_type       div_stat;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         max_cong_ff <= '0;
         stage_ff    <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MAX_CONGESTION: max_cong_ff <= csr_ch.data[MAXC_W-1:0];
            CSR_STAGE_COUNT:    stage_ff    <= csr_ch.data[STAGE_W-1:0];
            default:            ;
         endcase
      end
   end

   // saturating add of the packet size
   assign sum = {1'b0, count_ff} + {1'b0, req_ch.pkt_bytes};

   // shared multiplier: level product or divide-by-ten reciprocal
   assign mul_b = tick_ff ? DECAY_RECIP : MUL_W'(stage_ff);

   dcm_mul u_mul (
      .clock  (clock),
      .enable (state_ff == S_MUL),
      .op_a   (count_ff),
      .op_b   (mul_b),
      .prod   (prod)
   );

   assign divisor       = {1'b0, max_cong_ff} + DIVSR_W'(1);
   assign div_ctrl.start = (state_ff == S_DIV_GO);

   dcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (prod[DIVD_W-1:0]),
      .divisor  (divisor),
      .stat     (div_stat),
      .quotient (level)
   );

   // marking: larger of level and incoming value unless exempt
   assign ce_out   = (!no_mark_ff && (level > ce_in_ff)) ? level : ce_in_ff;
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ch.ready);

   // sequencer and counter
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_MUL;
               if (req_ch.cmd == CMD_PKT) begin
                  count_in = (sum > {1'b0, CNT_CEILING}) ? CNT_CEILING : sum[CNT_W-1:0];
               end
            end
         end
         S_MUL: begin
            state_in = tick_ff ? S_DECAY : S_DIV_GO;
         end
         S_DECAY: begin
            count_in = CNT_W'(prod[PROD_W-1:DECAY_SHIFT]);
            state_in = S_IDLE;
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response word valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // captured request fields and response word
   always_ff @(posedge clock) begin
      if (req_take) begin
         tick_ff    <= (req_ch.cmd == CMD_TICK);
         no_mark_ff <= req_ch.no_mark;
         ce_in_ff   <= req_ch.pkt_ce_in;
      end
      if (rsp_load) begin
         rsp_ce_ff    <= ce_out;
         rsp_level_ff <= level;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pkt_ce_out = rsp_ce_ff;
   assign rsp_ch.level      = rsp_level_ff;
   assign rsp_ch.byte_count = rsp_count_ff;

`ifndef SYNTHESIS
   // counter never exceeds its ceiling
   a_count_ceiling: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_CEILING)
      else $error("byte counter above ceiling");

   // a decay tick never raises the counter
   a_tick_decays: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.cmd == CMD_TICK) |-> ##3 (count_ff <= $past(count_ff, 3)))
      else $error("decay tick raised the counter");

   // divider only finishes while the sequencer waits for it, and is then idle
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> ((state_ff == S_DIV_WAIT) && !div_stat.busy))
      else $error("divider finished outside its wait state");

   // an exempt packet keeps its incoming value
   a_exempt_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && no_mark_ff) |=> (rsp_ch.pkt_ce_out == $past(ce_in_ff)))
      else $error("exempt packet was marked");
`endif

endmodule

`default_nettype wire

FILE: rtl/dcm_mul.sv
// ----------------------------------------------------------------------------
// dcm_mul
// shared registered 16 x 16 multiplier, used for the level product and for
// the reciprocal divide-by-ten of the decay
// ----------------------------------------------------------------------------
`default_nettype none

module dcm_mul (
   input  wire logic                       clock,
   input  wire logic                       enable,
   input  wire logic [dcm_pkg::MUL_W-1:0]  op_a,
   input  wire logic [dcm_pkg::MUL_W-1:0]  op_b,
   output logic      [dcm_pkg::PROD_W-1:0] prod
);
   import dcm_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   // product held until the next use
   always_comb begin
      prod_in = prod_ff;
      if (enable) begin
         prod_in = PROD_W'(op_a) * PROD_W'(op_b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: rtl/dcm_div.sv
// ----------------------------------------------------------------------------
// dcm_div
// restoring divider, one quotient bit a cycle, eight-bit quotient that
// saturates when the true quotient is 256 or more
// ----------------------------------------------------------------------------
`default_nettype none

module dcm_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dcm_pkg::div_ctrl_type        ctrl,
   input  wire logic [dcm_pkg::DIVD_W-1:0]   dividend,
   input  wire logic [dcm_pkg::DIVSR_W-1:0]  divisor,
   output dcm_pkg::div_stat_type             stat,
   output logic      [dcm_pkg::CE_W-1:0]     quotient
);
   import dcm_pkg::*;

   localparam int unsigned REM_W = DIVD_W - CE_W;

   logic [DIVD_W-1:0]  work_ff;
   logic [DIVD_W-1:0]  work_in;
   logic [STEP_W-1:0]  step_ff;
   logic [STEP_W-1:0]  step_in;
   logic               busy_ff;
   logic               busy_in;
   logic               done_ff;
   logic               done_in;
   logic               sat_ff;
   logic               sat_in;

   logic [DIVSR_W-1:0] trial;
   logic [DIVSR_W-1:0] diff;
   logic               fits;
   logic [REM_W-1:0]   rem_next;

   // one subtract and compare step; remainder stays below the divisor
   always_comb begin
      trial    = {work_ff[DIVD_W-1:CE_W], work_ff[CE_W-1]};
      fits     = (trial >= divisor);
      diff     = trial - divisor;
      rem_next = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
   end

   // step sequencing
   always_comb begin
      work_in = work_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      if (ctrl.start) begin
         work_in = dividend;
         step_in = '0;
         busy_in = 1'b1;
         // quotient of 256 or more when the upper part already reaches the divisor
         sat_in  = ({1'b0, dividend[DIVD_W-1:CE_W]} >= divisor);
      end else if (busy_ff) begin
         work_in = {rem_next, work_ff[CE_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      sat_ff  <= sat_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = sat_ff ? LEVEL_MAX : work_ff[CE_W-1:0];

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for dre_congestion_marker_core. The request and
// response channels are driven with random gaps and stalls. A scoreboard
// object keeps its own byte counter and quantiser and checks each response
// word against the oldest predicted mark. A directed opening covers the
// saturations, zero stages, exempt packets, decay to zero and ignored
// register indexes. It is followed by random phases at several settings.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import dcm_pkg::*;

   localparam int unsigned HALF_PERIOD   = 5;
   localparam int unsigned RESET_CYCLES  = 6;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned QUIET_LIMIT   = 4000;
   localparam int unsigned PHASES        = 6;
   localparam int unsigned PHASE_WORDS   = 180;
   localparam int unsigned IDLE_PERCENT  = 30;
   localparam int unsigned MAX_GAP       = 16;

   localparam logic [CNT_W-1:0]     DECAY_DIVISOR = 16'd10;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 8'hFF;

   // one predicted response word
   typedef struct packed {
      logic [CE_W-1:0]  ce_out;
      logic [CE_W-1:0]  level;
      logic [CNT_W-1:0] byte_count;
   } mark_word_type;

   // counter and quantiser copy, with the marks still to come
   class mark_scoreboard;
      logic [MAXC_W-1:0]  max_cong;
      logic [STAGE_W-1:0] stages;
      logic [CNT_W-1:0]   load;
      mark_word_type      marks_due[$];
      int unsigned        mismatches;
      int unsigned        marks_checked;

      function new();
         max_cong      = '0;
         stages        = '0;
         load          = '0;
         mismatches    = 0;
         marks_checked = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MAX_CONGESTION: max_cong = data[MAXC_W-1:0];
            CSR_STAGE_COUNT:    stages   = data[STAGE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_word(cmd_type cmd, logic [CNT_W-1:0] bytes,
                              logic [CE_W-1:0] ce_in, logic exempt);
         logic [CNT_W:0]    sum;
         logic [DIVD_W-1:0] prod;
         logic [DIVD_W-1:0] divisor;
         logic [DIVD_W-1:0] quot;
         mark_word_type     mark;
         // decay tick: counter divided by ten, nothing comes out
         if (cmd == CMD_TICK) begin
            load = load / DECAY_DIVISOR;
            return;
         end
         // saturating add of the packet size
         sum = {1'b0, load} + {1'b0, bytes};
         if (sum > {1'b0, CNT_CEILING}) begin
            sum = {1'b0, CNT_CEILING};
         end
         load = sum[CNT_W-1:0];
         // level = count * stages / (max + 1), clamped
         prod    = DIVD_W'(load) * DIVD_W'(stages);
         divisor = DIVD_W'(max_cong) + DIVD_W'(1);
         quot    = prod / divisor;
         mark.level      = (quot > DIVD_W'(LEVEL_MAX)) ? LEVEL_MAX : quot[CE_W-1:0];
         mark.ce_out     = (!exempt && mark.level > ce_in) ? mark.level : ce_in;
         mark.byte_count = load;
         marks_due.push_back(mark);
      endfunction

      function void check_mark(mark_word_type seen);
         mark_word_type want;
         if (marks_due.size() == 0) begin
            $error("response word with nothing expected: pkt_ce_out %0d level %0d byte_count %0d",
                   seen.ce_out, seen.level, seen.byte_count);
            mismatches++;
            return;
         end
         want = marks_due.pop_front();
         marks_checked++;
         if (seen.ce_out !== want.ce_out) begin
            $error("pkt_ce_out: expected %0d, actual %0d", want.ce_out, seen.ce_out);
            mismatches++;
         end
         if (seen.level !== want.level) begin
            $error("level: expected %0d, actual %0d", want.level, seen.level);
            mismatches++;
         end
         if (seen.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, actual %0d", want.byte_count, seen.byte_count);
            mismatches++;
         end
      endfunction

      function int unsigned outstanding();
         return marks_due.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        calm = 1'b0;
   logic        hold_request = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned packets_sent = 0;
   int unsigned ticks_sent = 0;
   int unsigned settings_used = 0;

   mark_scoreboard marks = new();

   dcm_req_if req_ch();
   dcm_rsp_if rsp_ch();
   dcm_csr_if csr_ch();

   dre_congestion_marker_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // clock
   always #(HALF_PERIOD) clock = ~clock;

   // monitors on all three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            marks.write_register(csr_ch.index, csr_ch.data);
         end
         if (req_ch.valid && req_ch.ready) begin
            marks.note_word(cmd_type'(req_ch.cmd), req_ch.pkt_bytes, req_ch.pkt_ce_in,
                            req_ch.no_mark);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            marks.check_mark({rsp_ch.pkt_ce_out, rsp_ch.level, rsp_ch.byte_count});
         end
      end
   end

   // cycles without any word moving
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // response ready: random stalls, calm stretches and one long hold-off
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // offer one request word, at times with a random gap in front of it
   task automatic offer_word(cmd_type w_cmd, logic [CNT_W-1:0] w_bytes,
                             logic [CE_W-1:0] w_ce, logic w_exempt);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.cmd       <= w_cmd;
      req_ch.pkt_bytes <= w_bytes;
      req_ch.pkt_ce_in <= w_ce;
      req_ch.no_mark   <= w_exempt;
      do @(posedge clock); while (!req_ch.ready);
      if (w_cmd == CMD_TICK) begin
         ticks_sent++;
      end else begin
         packets_sent++;
      end
   endtask

   // random word: mostly packets, sizes skewed small so ticks keep the count moving
   task automatic random_word();
      cmd_type          w_cmd;
      logic [CNT_W-1:0] w_bytes;
      logic [CE_W-1:0]  w_ce;
      logic             w_exempt;
      int unsigned      pick;
      w_cmd = ($urandom_range(99) < 25) ? CMD_TICK : CMD_PKT;
      pick  = $urandom_range(99);
      if (pick < 50) begin
         w_bytes = CNT_W'($urandom_range(0, 1500));
      end else if (pick < 80) begin
         w_bytes = CNT_W'($urandom_range(0, 16000));
      end else begin
         w_bytes = CNT_W'($urandom);
      end
      w_ce     = $urandom_range(1) ? CE_W'($urandom_range(0, 40)) : CE_W'($urandom);
      w_exempt = ($urandom_range(99) < 20);
      offer_word(w_cmd, w_bytes, w_ce, w_exempt);
   endtask

   // register write, valid left high for a following write
   task automatic post_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic set_registers(logic [MAXC_W-1:0] maxc, logic [STAGE_W-1:0] st);
      post_register(CSR_MAX_CONGESTION, CSR_DATA_W'(maxc));
      post_register(CSR_STAGE_COUNT, CSR_DATA_W'(st));
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // stop offering until every mark is back and a trailing tick has finished
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (marks.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus
   initial begin
      int unsigned phase;
      int unsigned n;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.cmd       <= CMD_PKT;
      req_ch.pkt_bytes <= '0;
      req_ch.pkt_ce_in <= '0;
      req_ch.no_mark   <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= '0;
      csr_ch.data      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero stages, level stays at zero
      offer_word(CMD_PKT, 16'd1000, 8'd7, 1'b0);
      offer_word(CMD_TICK, 16'd0, 8'd0, 1'b0);
      settle_block();

      // mid settings: counter and level saturation, exempt packets, decay to zero
      set_registers(16'd999, 8'd50);
      offer_word(CMD_PKT, 16'd0, 8'd0, 1'b0);
      offer_word(CMD_PKT, 16'd500, 8'd0, 1'b0);
      offer_word(CMD_PKT, 16'hFFFF, 8'd0, 1'b0);
      offer_word(CMD_PKT, 16'd1, 8'hFF, 1'b0);
      offer_word(CMD_PKT, 16'd0, 8'hFF, 1'b1);
      offer_word(CMD_TICK, 16'd0, 8'd0, 1'b0);
      offer_word(CMD_PKT, 16'd0, 8'd10, 1'b0);
      offer_word(CMD_TICK, 16'd0, 8'd0, 1'b0);
      offer_word(CMD_PKT, 16'd0, 8'd100, 1'b0);
      offer_word(CMD_PKT, 16'd0, 8'd20, 1'b1);
      offer_word(CMD_TICK, 16'd0, 8'd0, 1'b0);
      offer_word(CMD_TICK, 16'd0, 8'd0, 1'b0);
      offer_word(CMD_TICK, 16'd0, 8'd0, 1'b0);
      offer_word(CMD_PKT, 16'd0, 8'd0, 1'b0);
      offer_word(CMD_TICK, 16'hFFFF, 8'hFF, 1'b1);
      offer_word(CMD_PKT, 16'hFFFF, 8'd128, 1'b1);
      settle_block();

      // unused indexes must be ignored, then the widest divisor and stages
      post_register(CSR_UNUSED_LO, 16'hFFFF);
      post_register(CSR_UNUSED_HI, 16'h0000);
      set_registers(16'hFFFF, 8'hFF);
      offer_word(CMD_PKT, 16'hFFFF, 8'd0, 1'b0);
      offer_word(CMD_PKT, 16'd0, 8'hFF, 1'b0);
      settle_block();

      // divisor of one: level overflows at once
      set_registers(16'd0, 8'hFF);
      offer_word(CMD_TICK, 16'd0, 8'd0, 1'b0);
      offer_word(CMD_PKT, 16'd0, 8'd3, 1'b0);
      offer_word(CMD_PKT, 16'd0, 8'd0, 1'b1);
      settle_block();

      // random phases over a spread of settings
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       set_registers(16'd61999, 8'd255);
            1:       set_registers(16'd4095, 8'd16);
            2:       set_registers(16'd0, 8'd255);
            3:       set_registers(16'hFFFF, 8'd1);
            default: set_registers(MAXC_W'($urandom), STAGE_W'($urandom));
         endcase
         calm = (phase == 1);
         for (n = 0; n < PHASE_WORDS; n++) begin
            // long receiver hold-off while words keep coming
            if (phase == 0 && n == 40) begin
               hold_request = 1'b1;
            end
            // sender waits for every outstanding mark
            if (phase == 3 && n == PHASE_WORDS / 2) begin
               settle_block();
            end
            random_word();
         end
         calm = 1'b0;
         settle_block();
      end

      $display("covered %0d packet words and %0d decay ticks over %0d register settings,",
               packets_sent, ticks_sent, settings_used);
      $display("with %0d response words compared field by field", marks.marks_checked);
      if (marks.mismatches == 0 && marks.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
